/* rtl/core/fspa_pkg.sv */
// shared types and constants for the fixed slot pool allocator
`default_nettype none

package fspa_pkg;

  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 8;
  localparam int FLAGS_W  = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 3'd0,
    CMD_FREE  = 3'd1,
    CMD_SET   = 3'd2,
    CMD_GET   = 3'd3,
    CMD_MASK  = 3'd4,
    CMD_RESET = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOT_USED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_FIN
  } state_t;

  // control bundle from the sequencer to the slot memory
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } ram_ctl_t;

  // one result, status in the lowest bits
  typedef struct packed {
    logic                in_use;
    logic [FLAGS_W-1:0]  flags_out;
    logic [SLOT_W-1:0]   slot_out;
    status_t             status;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

/* rtl/core/fspa_slot_ram.sv */
// slot memory holding link, flags and used mark, with per-entry valid bits
`default_nettype none

module fspa_slot_ram
  import fspa_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int FW    = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  ram_ctl_t               ctl,
  input  wire  [$clog2(DEPTH)-1:0]     raddr,
  input  wire  [$clog2(DEPTH)-1:0]     waddr,
  input  wire  [$clog2(DEPTH):0]       wlink,
  input  wire  [FW-1:0]                wflags,
  input  wire                          wused,
  input  wire  [$clog2(DEPTH+1)-1:0]   active,
  output logic [$clog2(DEPTH):0]       rlink,
  output logic [FW-1:0]                rflags,
  output logic                         rused
);

  localparam int IW = $clog2(DEPTH);
  localparam int LW = IW + 1;
  localparam int WW = LW + FW + 1;

  logic [WW-1:0]    mem [DEPTH];
  logic [WW-1:0]    rd_word_r;
  logic             rd_vld_r;
  logic [IW-1:0]    rd_addr_r;
  logic [DEPTH-1:0] valid_r;
  logic [IW:0]      succ;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= {wlink, wflags, wused};
    end
    if (ctl.rd_en) begin
      rd_word_r <= mem[raddr];
      rd_vld_r  <= valid_r[raddr];
      rd_addr_r <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.clr) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  // an entry never written since the last relink reads as its relinked value
  always_comb begin
    succ = {1'b0, rd_addr_r} + 1'b1;
    if (rd_vld_r) begin
      rlink  = rd_word_r[WW-1 -: LW];
      rflags = rd_word_r[FW:1];
      rused  = rd_word_r[0];
    end else begin
      if (COUNT_W'(succ) < COUNT_W'(active)) begin
        rlink = {1'b0, succ[IW-1:0]};
      end else begin
        rlink = {1'b1, {IW{1'b0}}};
      end
      rflags = '0;
      rused  = 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fspa_out_reg.sv */
// result output register decoupling the sequencer from the result channel
`default_nettype none

module fspa_out_reg
  import fspa_pkg::*;
(
  input  wire           clk,
  input  wire           rst_n,
  input  wire           load,
  input  wire result_t  din,
  input  wire           out_tready,
  output logic          out_tvalid,
  output result_t       dout,
  output logic          can_load
);

  logic    valid_r;
  result_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= din;
    end
  end

  assign can_load   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign dout       = data_r;

endmodule

`default_nettype wire

/* rtl/core/fixed_slot_pool_allocator.sv */
// fixed slot pool allocator: LIFO free list over a slot memory
//
// Commands arrive as transactions on the in_ stream, one result per command
// leaves on the out_ stream. cfg_ writes slot_count, which takes effect at
// the next reset command (clamped to 1..min(NUM_SLOTS,256)).
// Alloc, free, set flags and get flags: one read of the slot memory in the
// accept cycle and the write back in S_EXEC, once the result can be loaded.
// Reset command and unknown codes go to S_FIN; a reset clears all valid
// bits at once, so no sweep is needed.
// Free by mask: one slot per cycle, the read of the next slot overlapping
// the write back of the current one.
// Results sit in an output register; the next command is accepted while a
// result waits. If the receiver stalls, the command in flight waits in
// S_EXEC or S_FIN until the output register frees up.
// After rst_n the pool holds 256 slots (or NUM_SLOTS if fewer), all free,
// linked in ascending order with slot zero at the head.
`default_nettype none

module fixed_slot_pool_allocator
  import fspa_pkg::*;
#(
  parameter int NUM_SLOTS = 256,
  parameter int FLAG_BITS = 16
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // command[2:0], slot[10:3], flags[26:11]
  input  wire  [IN_DATA_W-1:0]   in_tdata,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // status[1:0], slot_out[9:2], flags_out[25:10], in_use[26]
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  input  wire  [COUNT_W-1:0]     cfg_data,
  input  wire                    cfg_valid,
  output logic                   cfg_ready
);

  localparam int DEPTH = (NUM_SLOTS < 256) ? NUM_SLOTS : 256;
  localparam int IW    = $clog2(DEPTH);
  localparam int LW    = IW + 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int FW    = (FLAG_BITS < FLAGS_W) ? FLAG_BITS : FLAGS_W;
  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

  state_t          state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [FW-1:0]   flags_r, flags_nxt;
  logic [LW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   active_r, active_nxt;
  logic [IW-1:0]   cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] slot_count_r;

  ram_ctl_t        ram_ctl;
  logic [IW-1:0]   raddr, waddr;
  logic [LW-1:0]   wlink, rlink;
  logic [FW-1:0]   wflags, rflags;
  logic            wused, rused;

  logic            out_load, out_can_load;
  result_t         res, out_res;

  cmd_t              in_cmd;
  logic [SLOT_W-1:0] in_slot;
  logic [FLAGS_W-1:0] in_flags;
  logic [COUNT_W-1:0] clamped;
  logic [IW:0]        cnt_succ;
  logic               slot_bad;
  logic               head_empty;

  assign in_cmd   = cmd_t'(in_tdata[2:0]);
  assign in_slot  = in_tdata[10:3];
  assign in_flags = in_tdata[26:11];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= COUNT_RESET;
    end else if (cfg_valid) begin
      slot_count_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      active_r <= CW'(DEPTH);
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    slot_r  <= slot_nxt;
    flags_r <= flags_nxt;
    cnt_r   <= cnt_nxt;
  end

  always_comb begin
    if (slot_count_r == '0) begin
      clamped = COUNT_W'(1);
    end else if (slot_count_r > DEPTH_C) begin
      clamped = DEPTH_C;
    end else begin
      clamped = slot_count_r;
    end
  end

  assign cnt_succ   = {1'b0, cnt_r} + 1'b1;
  assign slot_bad   = COUNT_W'(slot_r) >= COUNT_W'(active_r);
  assign head_empty = head_r[IW] || (COUNT_W'(head_r[IW-1:0]) >= COUNT_W'(active_r));

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    slot_nxt   = slot_r;
    flags_nxt  = flags_r;
    head_nxt   = head_r;
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    ram_ctl    = '0;
    raddr      = '0;
    waddr      = '0;
    wlink      = rlink;
    wflags     = rflags;
    wused      = rused;
    in_tready  = 1'b0;
    out_load   = 1'b0;
    res        = '0;
    res.status = ST_OK;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt   = in_cmd;
          slot_nxt  = in_slot;
          flags_nxt = in_flags[FW-1:0];
          case (in_cmd)
            CMD_ALLOC: begin
              ram_ctl.rd_en = 1'b1;
              raddr         = head_r[IW-1:0];
              state_nxt     = S_EXEC;
            end
            CMD_FREE, CMD_SET, CMD_GET: begin
              ram_ctl.rd_en = 1'b1;
              raddr         = in_slot[IW-1:0];
              state_nxt     = S_EXEC;
            end
            CMD_MASK: begin
              ram_ctl.rd_en = 1'b1;
              raddr         = '0;
              cnt_nxt       = '0;
              state_nxt     = S_WALK;
            end
            CMD_RESET: begin
              ram_ctl.clr = 1'b1;
              head_nxt    = '0;
              active_nxt  = CW'(clamped);
              state_nxt   = S_FIN;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_EXEC: begin
        if (out_can_load) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          case (cmd_r)
            CMD_ALLOC: begin
              if (head_empty) begin
                res.status = ST_EMPTY;
              end else begin
                ram_ctl.wr_en = 1'b1;
                waddr         = head_r[IW-1:0];
                wflags        = flags_r;
                wused         = 1'b1;
                head_nxt      = rlink;
                res.slot_out  = SLOT_W'(head_r[IW-1:0]);
              end
            end
            CMD_GET: begin
              if (slot_bad) begin
                res.status = ST_RANGE;
              end else begin
                res.flags_out = FLAGS_W'(rflags);
                res.in_use    = rused;
              end
            end
            CMD_FREE, CMD_SET: begin
              if (slot_bad) begin
                res.status = ST_RANGE;
              end else if (!rused) begin
                res.status = ST_NOT_USED;
              end else begin
                ram_ctl.wr_en = 1'b1;
                waddr         = slot_r[IW-1:0];
                if (cmd_r == CMD_FREE) begin
                  wlink    = head_r;
                  wflags   = '0;
                  wused    = 1'b0;
                  head_nxt = {1'b0, slot_r[IW-1:0]};
                end else begin
                  wflags = flags_r;
                end
              end
            end
            default: begin
              res.status = ST_OK;
            end
          endcase
        end
      end

      S_WALK: begin
        // push the current slot, if in use and matching the mask, while the next one is being read
        if (rused && ((rflags & flags_r) != '0)) begin
          ram_ctl.wr_en = 1'b1;
          waddr         = cnt_r;
          wlink         = head_r;
          wflags        = '0;
          wused         = 1'b0;
          head_nxt      = {1'b0, cnt_r};
        end
        if (COUNT_W'(cnt_succ) < COUNT_W'(active_r)) begin
          ram_ctl.rd_en = 1'b1;
          raddr         = cnt_succ[IW-1:0];
          cnt_nxt       = cnt_succ[IW-1:0];
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (out_can_load) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  fspa_slot_ram #(
    .DEPTH (DEPTH),
    .FW    (FW)
  ) u_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ram_ctl),
    .raddr  (raddr),
    .waddr  (waddr),
    .wlink  (wlink),
    .wflags (wflags),
    .wused  (wused),
    .active (active_r),
    .rlink  (rlink),
    .rflags (rflags),
    .rused  (rused)
  );

  fspa_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .din        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .dout       (out_res),
    .can_load   (out_can_load)
  );

  assign out_tdata = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_res};

endmodule

`default_nettype wire
